[sv/gkti_pkg.sv]
// Shared types and codes for the keyed table block.
// Holds result codes, slot selection codes and the controller/datapath structs.
// Depends on nothing.
`default_nettype none

package gkti_pkg;

	// Default table size.
	localparam int DEF_TABLE_DEPTH = 16;

	// Result, key and value field widths.
	localparam int STATUS_W = 2;
	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 4;
	localparam int LIVE_W   = 5;
	localparam int KEY_W    = 64;
	localparam int VAL_W    = 64;

	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [1:0]          slot_sel_t;

	// Status codes.
	localparam status_t ST_SUCCESS      = 2'd0;
	localparam status_t ST_INVALID      = 2'd1;
	localparam status_t ST_NOT_FOUND    = 2'd2;
	localparam status_t ST_NO_RESOURCES = 2'd3;

	// Action codes.
	localparam action_t ACT_MODIFIED = 2'd0;
	localparam action_t ACT_DELETED  = 2'd1;
	localparam action_t ACT_ADDED    = 2'd2;
	localparam action_t ACT_NONE     = 2'd3;

	// Where the reported slot comes from.
	localparam slot_sel_t SLOT_ZERO = 2'd0;
	localparam slot_sel_t SLOT_IDX  = 2'd1;
	localparam slot_sel_t SLOT_CNT  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load_req;
		logic      rd_en;
		logic      rd_next;
		logic      inc_idx;
		logic      wr_val;
		logic      wr_shift;
		logic      wr_add;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      set_res;
		status_t   res_status;
		action_t   res_action;
		slot_sel_t res_slot;
		logic      load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic key_present;
		logic val_zero;
		logic cnt_zero;
		logic full;
		logic match;
		logic more;
		logic more2;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

[sv/gkti_dp.sv]
// Datapath of the keyed table: request registers, table memory, entry count,
// scan index, pending result and output register. Depends on gkti_pkg.
`default_nettype none

module gkti_dp
	import gkti_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic             key_present,
	input  wire logic [KEY_W-1:0] key_high,
	input  wire logic [KEY_W-1:0] key_low,
	input  wire logic [VAL_W-1:0] entry_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output status_t               status,
	output action_t               action,
	output logic [SLOT_W-1:0]     slot,
	output logic [LIVE_W-1:0]     live_entries
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = CNT_W + 1;

	// Table memory, one row per entry.
	logic [KEY_W-1:0] kh_mem [TABLE_DEPTH];
	logic [KEY_W-1:0] kl_mem [TABLE_DEPTH];
	logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

	logic             req_kp_q;
	logic [KEY_W-1:0] req_kh_q;
	logic [KEY_W-1:0] req_kl_q;
	logic [VAL_W-1:0] req_val_q;

	logic [KEY_W-1:0] rd_kh_q;
	logic [KEY_W-1:0] rd_kl_q;
	logic [VAL_W-1:0] rd_val_q;

	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;

	status_t          res_status_q;
	action_t          res_action_q;
	logic [SLOT_W-1:0] res_slot_q;

	logic             out_valid_q;
	status_t          out_status_q;
	action_t          out_action_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [LIVE_W-1:0] out_live_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_val_data;
	logic [CMP_W-1:0] idx_plus1;
	logic [CMP_W-1:0] idx_plus2;

	// Request capture; the scan always starts at entry zero.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_kp_q  <= key_present;
			req_kh_q  <= key_high;
			req_kl_q  <= key_low;
			req_val_q <= entry_value;
		end
	end

	// Read and write addresses of the single table port pair.
	assign idx_plus1   = CMP_W'(idx_q) + CMP_W'(1);
	assign idx_plus2   = CMP_W'(idx_q) + CMP_W'(2);
	assign rd_addr     = cmd.rd_next ? idx_plus1[IDX_W-1:0] : idx_q;
	assign wr_addr     = cmd.wr_add ? cnt_q[IDX_W-1:0] : idx_q;
	assign wr_val_data = cmd.wr_shift ? rd_val_q : req_val_q;

	// Table write port.
	always_ff @(posedge clk) begin
		if (cmd.wr_add || cmd.wr_shift) begin
			kh_mem[wr_addr] <= cmd.wr_shift ? rd_kh_q : req_kh_q;
			kl_mem[wr_addr] <= cmd.wr_shift ? rd_kl_q : req_kl_q;
		end
		if (cmd.wr_add || cmd.wr_shift || cmd.wr_val) begin
			val_mem[wr_addr] <= wr_val_data;
		end
	end

	// Table read port with registered data.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_kh_q  <= kh_mem[rd_addr];
			rd_kl_q  <= kl_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
	end

	// Scan index and live entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_plus1[IDX_W-1:0];
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Pending result, held while a delete compacts the table.
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			res_action_q <= cmd.res_action;
			case (cmd.res_slot)
				SLOT_IDX: res_slot_q <= SLOT_W'(idx_q);
				SLOT_CNT: res_slot_q <= SLOT_W'(cnt_q);
				default:  res_slot_q <= '0;
			endcase
		end
	end

	// Output register; the count is final by the time the beat is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_action_q <= res_action_q;
			out_slot_q   <= res_slot_q;
			out_live_q   <= LIVE_W'(cnt_q);
		end
	end

	// Status toward the controller.
	always_comb begin
		sts.key_present = req_kp_q;
		sts.val_zero    = (req_val_q == '0);
		sts.cnt_zero    = (cnt_q == '0);
		sts.full        = (cnt_q == CNT_W'(TABLE_DEPTH));
		sts.match       = (rd_kh_q == req_kh_q) && (rd_kl_q == req_kl_q);
		sts.more        = (idx_plus1 < CMP_W'(cnt_q));
		sts.more2       = (idx_plus2 < CMP_W'(cnt_q));
		sts.out_free    = !out_valid_q || !out_stall;
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign action       = out_action_q;
	assign slot         = out_slot_q;
	assign live_entries = out_live_q;

endmodule

`default_nettype wire

[sv/gkti_ctrl.sv]
// Controller of the keyed table: sequences scan, modify, add and the
// compacting delete. Depends on gkti_pkg.
`default_nettype none

module gkti_ctrl
	import gkti_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_START    = 3'd1;
	localparam logic [2:0] S_SCAN_RD  = 3'd2;
	localparam logic [2:0] S_SCAN_CMP = 3'd3;
	localparam logic [2:0] S_SHIFT_RD = 3'd4;
	localparam logic [2:0] S_SHIFT_WR = 3'd5;
	localparam logic [2:0] S_DONE     = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_START;
				end
			end
			S_START, S_SCAN_CMP: begin
				if ((state_q == S_START) && !sts.key_present) begin
					// Null key: report and change nothing.
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_INVALID;
					cmd.res_action = ACT_NONE;
					cmd.res_slot   = SLOT_ZERO;
					state_d        = S_DONE;
				end else if ((state_q == S_START) && !sts.cnt_zero) begin
					// Non-empty table: fetch entry zero.
					cmd.rd_en = 1'b1;
					state_d   = S_SCAN_CMP;
				end else if ((state_q == S_SCAN_CMP) && sts.match) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_SUCCESS;
					cmd.res_slot   = SLOT_IDX;
					if (!sts.val_zero) begin
						cmd.wr_val     = 1'b1;
						cmd.res_action = ACT_MODIFIED;
						state_d        = S_DONE;
					end else begin
						cmd.res_action = ACT_DELETED;
						if (sts.more) begin
							state_d = S_SHIFT_RD;
						end else begin
							cmd.cnt_dec = 1'b1;
							state_d     = S_DONE;
						end
					end
				end else if ((state_q == S_SCAN_CMP) && sts.more) begin
					cmd.inc_idx = 1'b1;
					state_d     = S_SCAN_RD;
				end else begin
					// No live entry matches.
					cmd.set_res  = 1'b1;
					cmd.res_slot = SLOT_ZERO;
					cmd.res_action = ACT_NONE;
					state_d      = S_DONE;
					if (sts.val_zero) begin
						cmd.res_status = ST_NOT_FOUND;
					end else if (sts.full) begin
						cmd.res_status = ST_NO_RESOURCES;
					end else begin
						cmd.wr_add     = 1'b1;
						cmd.cnt_inc    = 1'b1;
						cmd.res_status = ST_SUCCESS;
						cmd.res_action = ACT_ADDED;
						cmd.res_slot   = SLOT_CNT;
					end
				end
			end
			S_SCAN_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_SCAN_CMP;
			end
			S_SHIFT_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_next = 1'b1;
				state_d     = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				// Move the following entry down into the current slot.
				cmd.wr_shift = 1'b1;
				if (sts.more2) begin
					cmd.inc_idx = 1'b1;
					state_d     = S_SHIFT_RD;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/guid_keyed_table_install.sv]
// Top level of the keyed table with compacting delete.
// Joins gkti_ctrl and gkti_dp; depends on gkti_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  key_present, key_high, key_low, entry_value
//   out      output     out_valid / out_stall status, action, slot, live_entries
//
// One request is in work at a time. Its result beat is offered after the scan, and on a delete
// after the later entries are moved down; reads and moves never exceed the live count.
// The single table port, one access a cycle, sets this pace.
// Reset clears the entry count and the control state; table contents are not cleared.
// A result held under out_stall does not block the next request, whose result then waits.
`default_nettype none

module guid_keyed_table_install
	import gkti_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             key_present,
	input  wire logic [KEY_W-1:0] key_high,
	input  wire logic [KEY_W-1:0] key_low,
	input  wire logic [VAL_W-1:0] entry_value,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output status_t               status,
	output action_t               action,
	output logic [SLOT_W-1:0]     slot,
	output logic [LIVE_W-1:0]     live_entries
);

	cmd_t cmd;
	sts_t sts;

	gkti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	gkti_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.key_present  (key_present),
		.key_high     (key_high),
		.key_low      (key_low),
		.entry_value  (entry_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.action       (action),
		.slot         (slot),
		.live_entries (live_entries)
	);

	// An accepted beat keeps the input stalled while it is worked on.
	a_busy_after_accept: assert property (
		@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall
	) else $error("input not stalled after an accepted beat");

	// The live count never exceeds the table size.
	a_count_bound: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((TABLE_DEPTH > 31) || (live_entries <= LIVE_W'(TABLE_DEPTH)))
	) else $error("live entry count above table size");

	// A change to the table is always reported as a success, no change never is.
	a_action_status: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((action == ACT_NONE) == (status != ST_SUCCESS))
	) else $error("action and status disagree");

endmodule

`default_nettype wire

[verif/guid_keyed_table_install_test.sv]
// Self-checking testbench for guid_keyed_table_install, the keyed table with compacting delete.
// It predicts each request's result in a scoreboard class and drives the block with plain tasks.
// Depends on gkti_pkg and the guid_keyed_table_install RTL.

module guid_keyed_table_install_test;
	import gkti_pkg::*;

	localparam int DEPTH          = DEF_TABLE_DEPTH;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int KEY_POOL       = 24;
	localparam int DRAIN_CYCLES   = 4 * DEPTH + 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_CAP      = 40;

	typedef struct packed {
		status_t             status;
		action_t             action;
		logic [SLOT_W-1:0]   slot;
		logic [LIVE_W-1:0]   live;
	} table_result_t;

	// Mirrors the table contents and holds the results still owed by the block.
	class keyed_table_tracker;
		logic [KEY_W-1:0] key_hi[DEPTH];
		logic [KEY_W-1:0] key_lo[DEPTH];
		logic [VAL_W-1:0] val[DEPTH];
		int count;
		table_result_t owed[$];
		int errors;
		int n_checked;
		int n_added, n_modified, n_deleted, n_not_found, n_full, n_null;

		// Works out the result of one accepted request and updates the mirror.
		function void note_request(logic kp, logic [KEY_W-1:0] kh, logic [KEY_W-1:0] kl,
				logic [VAL_W-1:0] v);
			table_result_t r;
			int hit;
			hit = -1;
			r.status = ST_SUCCESS;
			r.action = ACT_NONE;
			r.slot = '0;
			if (!kp) begin
				r.status = ST_INVALID;
				n_null++;
			end else begin
				for (int i = 0; i < count; i++) begin
					if (hit < 0 && key_hi[i] == kh && key_lo[i] == kl)
						hit = i;
				end
				if (hit >= 0 && v != '0) begin
					val[hit] = v;
					r.action = ACT_MODIFIED;
					r.slot = hit[SLOT_W-1:0];
					n_modified++;
				end else if (hit >= 0) begin
					// Later entries move down one slot to keep the table packed.
					for (int i = hit; i + 1 < count; i++) begin
						key_hi[i] = key_hi[i+1];
						key_lo[i] = key_lo[i+1];
						val[i] = val[i+1];
					end
					count--;
					r.action = ACT_DELETED;
					r.slot = hit[SLOT_W-1:0];
					n_deleted++;
				end else if (v == '0) begin
					r.status = ST_NOT_FOUND;
					n_not_found++;
				end else if (count >= DEPTH) begin
					r.status = ST_NO_RESOURCES;
					n_full++;
				end else begin
					key_hi[count] = kh;
					key_lo[count] = kl;
					val[count] = v;
					r.action = ACT_ADDED;
					r.slot = count[SLOT_W-1:0];
					count++;
					n_added++;
				end
			end
			r.live = count[LIVE_W-1:0];
			owed.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $time, msg);
		endtask

		// Compares one result beat against the oldest owed result.
		task check_result(status_t st, action_t ac, logic [SLOT_W-1:0] sl,
				logic [LIVE_W-1:0] le);
			table_result_t e;
			if (owed.size() == 0) begin
				report($sformatf("result with none owed: status %0d action %0d slot %0d live %0d",
					st, ac, sl, le));
			end else begin
				e = owed.pop_front();
				n_checked++;
				if (st !== e.status)
					report($sformatf("result %0d status %0d, want %0d", n_checked, st, e.status));
				if (ac !== e.action)
					report($sformatf("result %0d action %0d, want %0d", n_checked, ac, e.action));
				if (sl !== e.slot)
					report($sformatf("result %0d slot %0d, want %0d", n_checked, sl, e.slot));
				if (le !== e.live)
					report($sformatf("result %0d live %0d, want %0d", n_checked, le, e.live));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              key_present;
	logic [KEY_W-1:0]  key_high;
	logic [KEY_W-1:0]  key_low;
	logic [VAL_W-1:0]  entry_value;
	logic              out_valid;
	logic              out_stall;
	status_t           status;
	action_t           action;
	logic [SLOT_W-1:0] slot;
	logic [LIVE_W-1:0] live_entries;

	keyed_table_tracker sb = new();
	logic [KEY_W-1:0] pool_hi[KEY_POOL];
	logic [KEY_W-1:0] pool_lo[KEY_POOL];
	bit no_idle;
	bit hold_done;
	int hold_left;
	int quiet_cycles;

	guid_keyed_table_install #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_present(key_present),
		.key_high(key_high),
		.key_low(key_low),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.action(action),
		.slot(slot),
		.live_entries(live_entries)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Nonzero value, now and then at an extreme.
	function automatic logic [VAL_W-1:0] rand_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(9))
			0: v = '1;
			1: v = 64'd1;
			default: v = rand64();
		endcase
		if (v == '0)
			v = 64'd1;
		return v;
	endfunction

	// Offers one request beat, with random idling first, and notes it once accepted.
	task automatic send_request(input logic kp, input logic [KEY_W-1:0] kh,
			input logic [KEY_W-1:0] kl, input logic [VAL_W-1:0] v);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		key_present <= kp;
		key_high <= kh;
		key_low <= kl;
		entry_value <= v;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(kp, kh, kl, v);
	endtask

	// Picks one random request; the mix swings between filling and draining phases.
	task automatic random_request(input int n);
		int pick;
		int idx;
		int add_weight;
		logic kp;
		logic [KEY_W-1:0] kh;
		logic [KEY_W-1:0] kl;
		logic [VAL_W-1:0] v;
		kp = 1'b1;
		v = rand_value();
		add_weight = ((n / 150) % 2 == 0) ? 45 : 20;
		pick = $urandom_range(99);
		idx = $urandom_range(KEY_POOL - 1);
		kh = pool_hi[idx];
		kl = pool_lo[idx];
		if (pick < 4) begin
			kp = 1'b0;
			kh = rand64();
			kl = rand64();
			if ($urandom_range(1) == 0)
				v = '0;
		end else if (pick < 4 + add_weight) begin
			// Pool key with a nonzero value: an add, or a modify if it is live.
		end else if (pick < 70 && sb.count > 0) begin
			idx = $urandom_range(sb.count - 1);
			kh = sb.key_hi[idx];
			kl = sb.key_lo[idx];
			if ($urandom_range(1) == 0)
				v = '0;
		end else if (pick < 85) begin
			kh = rand64();
			kl = rand64();
			if ($urandom_range(1) == 0)
				v = '0;
		end else if ($urandom_range(2) == 0) begin
			v = '0;
		end
		send_request(kp, kh, kl, v);
	endtask

	// Receiver: random stalls, one long hold-off, and a quiet window.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && sb.n_checked >= 400) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (no_idle) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 19);
			end
		end
	end

	// Result monitor and watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(status, action, slot, live_entries);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("guid_keyed_table_install_test: done, errors");
				$finish;
			end
		end
	end

	// Reset, directed requests, random requests, then drain and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_present = 1'b0;
		key_high = '0;
		key_low = '0;
		entry_value = '0;
		no_idle = 1'b0;
		quiet_cycles = 0;

		// Key pool with some keys sharing one half with a neighbor.
		for (int i = 0; i < KEY_POOL; i++) begin
			pool_hi[i] = rand64();
			pool_lo[i] = rand64();
			if (i % 4 == 1)
				pool_hi[i] = pool_hi[i-1];
			if (i % 4 == 2)
				pool_lo[i] = pool_lo[i-1];
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Null key, miss on an empty table, adds at the key extremes.
		send_request(1'b0, '1, '1, '1);
		send_request(1'b1, '0, '0, '0);
		send_request(1'b1, '0, '0, '1);
		send_request(1'b1, '1, '1, 64'd1);
		send_request(1'b1, '1, '0, 64'h8000_0000_0000_0000);
		send_request(1'b1, '0, '1, 64'h0000_0000_0000_1234);
		// Modify, null key naming a live entry, delete in the middle, then miss.
		send_request(1'b1, '0, '0, 64'h5555_5555_5555_5555);
		send_request(1'b0, '1, '1, '0);
		send_request(1'b1, '1, '1, '0);
		send_request(1'b1, '1, '1, '0);
		// Fill the table to the last slot, then an add to the full table.
		while (sb.count < DEPTH)
			send_request(1'b1, {32'hC0DE_0000, 32'(sb.count)}, rand64(), rand_value());
		send_request(1'b1, 64'd1, 64'd2, rand_value());
		// Delete the first entry and then the last one.
		send_request(1'b1, '0, '0, '0);
		send_request(1'b1, sb.key_hi[sb.count-1], sb.key_lo[sb.count-1], '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 800 && n < 1100);
			random_request(n);
		end
		no_idle = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d results: %0d added, %0d modified, %0d deleted",
			sb.n_checked, sb.n_added, sb.n_modified, sb.n_deleted);
		$display("refused: %0d null key, %0d not found, %0d table full; %0d mismatches",
			sb.n_null, sb.n_not_found, sb.n_full, sb.errors);
		if (sb.errors == 0) begin
			$display("guid_keyed_table_install_test: done, clean");
		end else begin
			$display("guid_keyed_table_install_test: done, errors");
		end
		$finish;
	end

endmodule

[guid_keyed_table_install.f]
sv/gkti_pkg.sv
sv/gkti_dp.sv
sv/gkti_ctrl.sv
sv/guid_keyed_table_install.sv
verif/guid_keyed_table_install_test.sv
